/* rtl/tilt_eq_shelf_cascade_assert.svh */
// ----------------------------------------------------------------------------
// Tilt EQ shelf cascade: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TILT_EQ_SHELF_CASCADE_ASSERT_SVH
`define TILT_EQ_SHELF_CASCADE_ASSERT_SVH

// same-cycle implication
`define TES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TES_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tes_pkg.sv */
// ----------------------------------------------------------------------------
// Tilt EQ shelf cascade: package
// Widths, register codes, control word layout and the microcode program.
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 24;
  localparam int CHAN_W       = 3;
  localparam int COEF_W       = 24;
  localparam int PAIR_W       = 2 * COEF_W;
  localparam int NUM_REGS     = 5;
  localparam int REG_IDX_W    = 3;
  localparam int HIST_W       = 40;
  localparam int HIST_DEPTH   = NUM_CHANNELS * 4;
  localparam int HIST_AW      = $clog2(HIST_DEPTH);
  localparam int FRAC_Y       = 20;
  localparam int FRAC_Z       = 8;
  localparam int PROD_W       = COEF_W + SAMPLE_BITS;
  localparam int ACC_W        = ((PROD_W > HIST_W + FRAC_Z) ? PROD_W : HIST_W + FRAC_Z) + 2;
  localparam int PROG_LEN     = 20;
  localparam int STEP_W       = $clog2(PROG_LEN);
  localparam int STEP_PASS    = 17;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_A1,
    REG_A2
  } coef_e;

  localparam logic [PAIR_W-1:0] COEF_RESET [NUM_REGS] = '{
    48'h1000_0010_0000, 48'h0, 48'h0, 48'h0, 48'h0
  };

  typedef enum logic {
    SRC_X,
    SRC_Y
  } src_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_LOAD_PROD,
    ACC_SUB_PROD,
    ACC_ADD_HIST,
    ACC_LOAD_X
  } acc_e;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_BADCH,
    JMP_WAIT,
    JMP_WAIT_END,
    JMP_END
  } jmp_e;

  typedef struct packed {
    logic              mul_en;
    coef_e             coef_sel;
    logic              coef_hi;
    src_e              mul_src;
    acc_e              acc_op;
    logic              rd_en;
    logic              wr_en;
    logic              hstage;
    logic              hword;
    logic              y_ld;
    logic              x_ld;
    logic              emit;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic   start;
    ucode_t uc;
  } ctrl_t;

  typedef struct packed {
    logic bad_chan;
    logic out_busy;
  } stat_t;

  // Program: low shelf in steps 0..8, high shelf in 8..16, pass-through in 17..19.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    case (int'(step))
      0: begin
        w.mul_en = 1'b1; w.coef_sel = REG_B0; w.mul_src = SRC_X;
        w.jmp = JMP_BADCH; w.target = STEP_W'(STEP_PASS);
      end
      1: begin
        w.acc_op = ACC_LOAD_PROD; w.rd_en = 1'b1;
        w.mul_en = 1'b1; w.coef_sel = REG_B1; w.mul_src = SRC_X;
      end
      2: begin
        w.acc_op = ACC_ADD_HIST; w.rd_en = 1'b1; w.hword = 1'b1;
      end
      3: begin
        w.y_ld = 1'b1; w.acc_op = ACC_LOAD_PROD;
      end
      4: begin
        w.acc_op = ACC_ADD_HIST;
        w.mul_en = 1'b1; w.coef_sel = REG_A1; w.mul_src = SRC_Y;
      end
      5: begin
        w.acc_op = ACC_SUB_PROD;
        w.mul_en = 1'b1; w.coef_sel = REG_B2; w.mul_src = SRC_X;
      end
      6: begin
        w.wr_en = 1'b1; w.acc_op = ACC_LOAD_PROD;
        w.mul_en = 1'b1; w.coef_sel = REG_A2; w.mul_src = SRC_Y;
      end
      7: begin
        w.acc_op = ACC_SUB_PROD;
      end
      8: begin
        w.wr_en = 1'b1; w.hword = 1'b1; w.x_ld = 1'b1;
        w.mul_en = 1'b1; w.coef_sel = REG_B0; w.coef_hi = 1'b1; w.mul_src = SRC_Y;
      end
      9: begin
        w.acc_op = ACC_LOAD_PROD; w.rd_en = 1'b1; w.hstage = 1'b1;
        w.mul_en = 1'b1; w.coef_sel = REG_B1; w.coef_hi = 1'b1; w.mul_src = SRC_X;
      end
      10: begin
        w.acc_op = ACC_ADD_HIST; w.rd_en = 1'b1; w.hstage = 1'b1; w.hword = 1'b1;
      end
      11: begin
        w.y_ld = 1'b1; w.acc_op = ACC_LOAD_PROD;
      end
      12: begin
        w.acc_op = ACC_ADD_HIST; w.emit = 1'b1; w.jmp = JMP_WAIT;
        w.mul_en = 1'b1; w.coef_sel = REG_A1; w.coef_hi = 1'b1; w.mul_src = SRC_Y;
      end
      13: begin
        w.acc_op = ACC_SUB_PROD;
        w.mul_en = 1'b1; w.coef_sel = REG_B2; w.coef_hi = 1'b1; w.mul_src = SRC_X;
      end
      14: begin
        w.wr_en = 1'b1; w.hstage = 1'b1; w.acc_op = ACC_LOAD_PROD;
        w.mul_en = 1'b1; w.coef_sel = REG_A2; w.coef_hi = 1'b1; w.mul_src = SRC_Y;
      end
      15: begin
        w.acc_op = ACC_SUB_PROD;
      end
      16: begin
        w.wr_en = 1'b1; w.hstage = 1'b1; w.hword = 1'b1; w.jmp = JMP_END;
      end
      17: begin
        w.acc_op = ACC_LOAD_X;
      end
      18: begin
        w.y_ld = 1'b1;
      end
      19: begin
        w.emit = 1'b1; w.jmp = JMP_WAIT_END;
      end
      default: begin
        w.jmp = JMP_END;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/tes_stream_if.sv */
// ----------------------------------------------------------------------------
// Tilt EQ shelf cascade: stream interfaces
// Valid/ready channels for input samples and filtered results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tes_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [tes_pkg::CHAN_W-1:0]            chan_index;
  logic signed [tes_pkg::SAMPLE_BITS-1:0] sample_in;
  logic                                  block_end;

  modport source (output valid, chan_index, sample_in, block_end, input ready);
  modport sink   (input valid, chan_index, sample_in, block_end, output ready);
endinterface

interface tes_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [tes_pkg::CHAN_W-1:0]            chan_out;
  logic signed [tes_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                  block_end_out;
  logic                                  clipped;

  modport source (output valid, chan_out, sample_out, block_end_out, clipped, input ready);
  modport sink   (input valid, chan_out, sample_out, block_end_out, clipped, output ready);
endinterface

`default_nettype wire

/* rtl/tes_sequencer.sv */
// ----------------------------------------------------------------------------
// Tilt EQ shelf cascade: microcode sequencer
// Step counter over the control program, with wait and branch handling.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tilt_eq_shelf_cascade_assert.svh"

module tes_sequencer (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire tes_pkg::stat_t  stat_i,
  output tes_pkg::ctrl_t       ctrl_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                       state_q, state_d;
  logic [tes_pkg::STEP_W-1:0]   step_q, step_d;
  tes_pkg::ucode_t              uc;
  logic                         stall;

  always_comb begin
    uc    = tes_pkg::ucode_rom(step_q);
    // hold the emitting step while the result slot is still occupied
    stall = ((uc.jmp == tes_pkg::JMP_WAIT) || (uc.jmp == tes_pkg::JMP_WAIT_END)) &&
            stat_i.out_busy;
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        if (!stall) begin
          case (uc.jmp)
            tes_pkg::JMP_NEXT, tes_pkg::JMP_WAIT: begin
              step_d = step_q + 1'b1;
            end
            tes_pkg::JMP_BADCH: begin
              step_d = stat_i.bad_chan ? uc.target : step_q + 1'b1;
            end
            default: begin
              state_d = ST_IDLE;
              step_d  = '0;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign ctrl_o.start = in_valid_i && in_ready_o;
  assign ctrl_o.uc    = ((state_q == ST_RUN) && !stall) ? uc : '0;

  `TES_ASSERT_NXT(a_start_at_zero, ctrl_o.start, (state_q == ST_RUN) && (step_q == '0), "item did not start at step zero")
  `TES_ASSERT_IMP(a_step_range, state_q == ST_RUN, step_q < tes_pkg::STEP_W'(tes_pkg::PROG_LEN), "step counter left the program")
  `TES_ASSERT_NXT(a_stall_holds, (state_q == ST_RUN) && stall, (state_q == ST_RUN) && $stable(step_q), "stalled step advanced")

endmodule

`default_nettype wire

/* rtl/tes_datapath.sv */
// ----------------------------------------------------------------------------
// Tilt EQ shelf cascade: datapath
// Coefficient registers, shared multiply-accumulate, history memory and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tilt_eq_shelf_cascade_assert.svh"

module tes_datapath (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire tes_pkg::ctrl_t                     ctrl_i,
  output tes_pkg::stat_t                          stat_o,
  input  wire [tes_pkg::CHAN_W-1:0]               chan_i,
  input  wire signed [tes_pkg::SAMPLE_BITS-1:0]   sample_i,
  input  wire                                     block_end_i,
  input  wire                                     cfg_we_i,
  input  wire [tes_pkg::REG_IDX_W-1:0]            cfg_index_i,
  input  wire [tes_pkg::PAIR_W-1:0]               cfg_data_i,
  input  wire                                     out_ready_i,
  output logic                                    out_valid_o,
  output logic [tes_pkg::CHAN_W-1:0]              out_chan_o,
  output logic signed [tes_pkg::SAMPLE_BITS-1:0]  out_sample_o,
  output logic                                    out_block_end_o,
  output logic                                    out_clipped_o
);

  localparam int RND_W = tes_pkg::ACC_W + 1;
  localparam logic signed [RND_W-1:0] Y_HALF = RND_W'(64'sd1 <<< (tes_pkg::FRAC_Y - 1));
  localparam logic signed [RND_W-1:0] Z_HALF = RND_W'(64'sd1 <<< (tes_pkg::FRAC_Z - 1));
  localparam logic signed [RND_W-1:0] SMP_MAX =
    RND_W'((64'sd1 <<< (tes_pkg::SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] SMP_MIN =
    RND_W'(-(64'sd1 <<< (tes_pkg::SAMPLE_BITS - 1)));
  localparam logic signed [RND_W-1:0] HST_MAX =
    RND_W'((64'sd1 <<< (tes_pkg::HIST_W - 1)) - 64'sd1);
  localparam logic signed [RND_W-1:0] HST_MIN =
    RND_W'(-(64'sd1 <<< (tes_pkg::HIST_W - 1)));

  logic [tes_pkg::PAIR_W-1:0]             coef_q [tes_pkg::NUM_REGS];
  logic                                   cfg_hit;
  logic [tes_pkg::PAIR_W-1:0]             coef_word;
  logic signed [tes_pkg::COEF_W-1:0]      mul_a;
  logic signed [tes_pkg::SAMPLE_BITS-1:0] mul_b;

  logic [tes_pkg::CHAN_W-1:0]             chan_q;
  logic signed [tes_pkg::SAMPLE_BITS-1:0] x_q;
  logic signed [tes_pkg::SAMPLE_BITS-1:0] y_q;
  logic                                   blk_q;
  logic                                   clip_q;
  logic signed [tes_pkg::PROD_W-1:0]      prod_q;
  logic signed [tes_pkg::ACC_W-1:0]       acc_q;
  logic signed [tes_pkg::HIST_W-1:0]      hist_q;

  logic signed [tes_pkg::HIST_W-1:0]      hist_mem [tes_pkg::HIST_DEPTH];
  logic [tes_pkg::HIST_DEPTH-1:0]         hist_vld_q;
  logic [tes_pkg::HIST_AW-1:0]            hist_addr;

  logic signed [RND_W-1:0]                acc_wide, y_rnd, z_rnd;
  logic signed [tes_pkg::SAMPLE_BITS-1:0] y_sat;
  logic                                   y_hit;
  logic signed [tes_pkg::HIST_W-1:0]      z_sat;
  logic                                   bad_chan;
  logic                                   out_valid_q;

  // Configuration: a write to a listed register also drops all history.
  assign cfg_hit = cfg_we_i && (cfg_index_i < tes_pkg::REG_IDX_W'(tes_pkg::NUM_REGS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tes_pkg::NUM_REGS; i++) begin
        coef_q[i] <= tes_pkg::COEF_RESET[i];
      end
    end else if (cfg_hit) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_comb begin
    coef_word = coef_q[ctrl_i.uc.coef_sel];
    mul_a     = ctrl_i.uc.coef_hi ? coef_word[tes_pkg::PAIR_W-1:tes_pkg::COEF_W]
                                  : coef_word[tes_pkg::COEF_W-1:0];
    mul_b     = (ctrl_i.uc.mul_src == tes_pkg::SRC_Y) ? y_q : x_q;
  end

  // Round-to-nearest and saturation of the accumulator for output and history.
  always_comb begin
    acc_wide = RND_W'(acc_q);
    y_rnd    = (acc_wide + Y_HALF) >>> tes_pkg::FRAC_Y;
    z_rnd    = (acc_wide + Z_HALF) >>> tes_pkg::FRAC_Z;
    y_hit    = 1'b1;
    if (y_rnd > SMP_MAX) begin
      y_sat = SMP_MAX[tes_pkg::SAMPLE_BITS-1:0];
    end else if (y_rnd < SMP_MIN) begin
      y_sat = SMP_MIN[tes_pkg::SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_rnd[tes_pkg::SAMPLE_BITS-1:0];
      y_hit = 1'b0;
    end
    if (z_rnd > HST_MAX) begin
      z_sat = HST_MAX[tes_pkg::HIST_W-1:0];
    end else if (z_rnd < HST_MIN) begin
      z_sat = HST_MIN[tes_pkg::HIST_W-1:0];
    end else begin
      z_sat = z_rnd[tes_pkg::HIST_W-1:0];
    end
  end

  assign hist_addr = tes_pkg::HIST_AW'({chan_q, ctrl_i.uc.hstage, ctrl_i.uc.hword});
  assign bad_chan  = (32'(chan_q) >= 32'(tes_pkg::NUM_CHANNELS));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      chan_q <= chan_i;
      x_q    <= sample_i;
      blk_q  <= block_end_i;
      clip_q <= 1'b0;
    end else begin
      if (ctrl_i.uc.x_ld) begin
        x_q <= y_q;
      end
      if (ctrl_i.uc.y_ld) begin
        clip_q <= clip_q | y_hit;
      end
    end
    if (ctrl_i.uc.y_ld) begin
      y_q <= y_sat;
    end
    if (ctrl_i.uc.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    case (ctrl_i.uc.acc_op)
      tes_pkg::ACC_LOAD_PROD: acc_q <= tes_pkg::ACC_W'(prod_q);
      tes_pkg::ACC_SUB_PROD:  acc_q <= acc_q - tes_pkg::ACC_W'(prod_q);
      tes_pkg::ACC_ADD_HIST:  acc_q <= acc_q + (tes_pkg::ACC_W'(hist_q) <<< tes_pkg::FRAC_Z);
      tes_pkg::ACC_LOAD_X:    acc_q <= tes_pkg::ACC_W'(x_q) <<< tes_pkg::FRAC_Y;
      default:                acc_q <= acc_q;
    endcase
  end

  // History memory; a word never written since the last clear reads as zero.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.uc.wr_en) begin
      hist_mem[hist_addr] <= z_sat;
    end
    if (ctrl_i.uc.rd_en) begin
      hist_q <= hist_vld_q[hist_addr] ? hist_mem[hist_addr] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
    end else if (cfg_hit) begin
      hist_vld_q <= '0;
    end else if (ctrl_i.uc.wr_en) begin
      hist_vld_q[hist_addr] <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.uc.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.uc.emit) begin
      out_chan_o      <= chan_q;
      out_sample_o    <= y_q;
      out_block_end_o <= blk_q;
      out_clipped_o   <= clip_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.bad_chan = bad_chan;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  `TES_ASSERT_IMP(a_emit_slot_free, ctrl_i.uc.emit, !out_valid_q || out_ready_i, "result overwritten before taken")
  `TES_ASSERT_IMP(a_hist_chan_valid, ctrl_i.uc.wr_en || ctrl_i.uc.rd_en, !bad_chan, "history access for out-of-range channel")
  `TES_ASSERT_IMP(a_no_rw_clash, ctrl_i.uc.wr_en, !ctrl_i.uc.rd_en, "history read and write in one step")

endmodule

`default_nettype wire

/* rtl/tilt_eq_shelf_cascade.sv */
// Items are taken one at a time: a new item is accepted only after the
// single shared multiply-accumulate has run the program for the last one;
// a channel out of range passes through unfiltered on a shorter path.
// Reset: coefficients return to b0 = 1.0 and the rest zero; history reads as
// zero through per-word valid bits, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
// Tilt EQ shelf cascade: top level
// Low-shelf then high-shelf biquad per channel, microcoded on one MAC.
// ----------------------------------------------------------------------------
`default_nettype none

module tilt_eq_shelf_cascade (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  tes_in_if.sink                            smp_i,
  tes_out_if.source                         res_o,
  input  wire                               cfg_we_i,
  input  wire [tes_pkg::REG_IDX_W-1:0]      cfg_index_i,
  input  wire [tes_pkg::PAIR_W-1:0]         cfg_data_i
);

  tes_pkg::ctrl_t ctrl;
  tes_pkg::stat_t stat;

  tes_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (smp_i.valid),
    .in_ready_o (smp_i.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  tes_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .chan_i          (smp_i.chan_index),
    .sample_i        (smp_i.sample_in),
    .block_end_i     (smp_i.block_end),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (res_o.ready),
    .out_valid_o     (res_o.valid),
    .out_chan_o      (res_o.chan_out),
    .out_sample_o    (res_o.sample_out),
    .out_block_end_o (res_o.block_end_out),
    .out_clipped_o   (res_o.clipped)
  );

endmodule

`default_nettype wire

/* tb/tilt_eq_shelf_cascade_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt EQ shelf cascade: testbench
// Streams tagged audio samples through the low/high shelf cascade under a
// series of coefficient sets, from identity and full-scale extremes to
// random and well-behaved filters, and checks every filtered result field
// against a bit-true fixed-point model of both biquad stages.
// ----------------------------------------------------------------------------

module tilt_eq_shelf_cascade_tb;

  localparam int     HALF_PERIOD   = 6;
  localparam int     RESET_CYCLES  = 7;
  localparam int     SETTLE_CYCLES = 24;
  localparam int     MAX_WAIT      = 6;
  localparam int     PHASE_ITEMS   = 56;
  localparam longint TIMEOUT_NS    = 4_000_000;

  localparam logic [tes_pkg::COEF_W-1:0] COEF_MAX = 24'h7F_FFFF;
  localparam logic [tes_pkg::COEF_W-1:0] COEF_MIN = 24'h80_0000;
  localparam int                         COEF_ONE = 'h10_0000;

  localparam longint SMP_MAX  = (longint'(1) <<< (tes_pkg::SAMPLE_BITS - 1)) - 1;
  localparam longint SMP_MIN  = -SMP_MAX - 1;
  localparam longint HIST_MAX = (longint'(1) <<< (tes_pkg::HIST_W - 1)) - 1;
  localparam longint HIST_MIN = -HIST_MAX - 1;

  typedef enum int {
    CFG_DEFAULT,
    CFG_MAX,
    CFG_MIN,
    CFG_ONES,
    CFG_RANDOM,
    CFG_GENTLE,
    CFG_SPARE,
    CFG_MIXED
  } coef_set_e;

  localparam coef_set_e PLAN [12] = '{
    CFG_GENTLE, CFG_MAX, CFG_SPARE, CFG_MIN, CFG_RANDOM, CFG_ONES,
    CFG_MIXED, CFG_GENTLE, CFG_SPARE, CFG_MIXED, CFG_RANDOM, CFG_DEFAULT
  };

  localparam logic signed [tes_pkg::SAMPLE_BITS-1:0] EDGE_SAMPLES [10] = '{
    24'sh7F_FFFF, 24'sh80_0000, 24'sh00_0000, 24'shFF_FFFF, 24'sh00_0001,
    24'sh55_5555, 24'shAA_AAAA, 24'sh00_0FFF, 24'sh40_0000, 24'shC0_0000
  };

  typedef struct {
    logic [tes_pkg::CHAN_W-1:0]             chan;
    logic signed [tes_pkg::SAMPLE_BITS-1:0] sample;
    logic                                   last;
  } audio_t;

  typedef struct {
    logic [tes_pkg::CHAN_W-1:0]             chan;
    logic signed [tes_pkg::SAMPLE_BITS-1:0] sample;
    logic                                   last;
    logic                                   clip;
  } filtered_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [tes_pkg::REG_IDX_W-1:0] cfg_index_i;
  logic [tes_pkg::PAIR_W-1:0]    cfg_data_i;

  tes_in_if  smp ();
  tes_out_if res ();

  tilt_eq_shelf_cascade dut (
    .clk_i,
    .rst_ni,
    .smp_i      (smp),
    .res_o      (res),
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i
  );

  audio_t                     sample_feed [$];
  filtered_t                  filtered_due [$];
  logic [tes_pkg::PAIR_W-1:0] coef_pair [tes_pkg::NUM_REGS];
  longint                     hist [tes_pkg::HIST_DEPTH];
  int                         err_count;
  bit                         no_idle;
  bit                         in_fire;
  bit                         out_fire;
  int                         in_gap;
  int                         out_stall;

  always begin
    clk_i = 1'b0;
    #(HALF_PERIOD);
    clk_i = 1'b1;
    #(HALF_PERIOD);
  end

  // ---------------------------------------------------------------------------
  // Fixed-point model of the cascade
  // ---------------------------------------------------------------------------
  function automatic longint coef_of(tes_pkg::coef_e r, bit upper);
    logic signed [tes_pkg::COEF_W-1:0] c;
    c = upper ? coef_pair[r][tes_pkg::PAIR_W-1:tes_pkg::COEF_W]
              : coef_pair[r][tes_pkg::COEF_W-1:0];
    return c;
  endfunction

  function automatic longint saturate(longint v, longint lo, longint hi, inout bit hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint shelf_stage(int base, bit upper, longint x, inout bit clip);
    longint acc;
    longint y;
    longint n1;
    longint n2;
    bit     spill;
    spill = 1'b0;
    acc = coef_of(tes_pkg::REG_B0, upper) * x + (hist[base] <<< tes_pkg::FRAC_Z);
    y   = saturate((acc + (longint'(1) <<< (tes_pkg::FRAC_Y - 1))) >>> tes_pkg::FRAC_Y,
                   SMP_MIN, SMP_MAX, clip);
    // the saturated output drives the feedback terms
    n1  = coef_of(tes_pkg::REG_B1, upper) * x - coef_of(tes_pkg::REG_A1, upper) * y
          + (hist[base + 1] <<< tes_pkg::FRAC_Z);
    n2  = coef_of(tes_pkg::REG_B2, upper) * x - coef_of(tes_pkg::REG_A2, upper) * y;
    // history overflow clamps silently, it never raises the clip flag
    hist[base]     = saturate((n1 + (longint'(1) <<< (tes_pkg::FRAC_Z - 1)))
                              >>> tes_pkg::FRAC_Z, HIST_MIN, HIST_MAX, spill);
    hist[base + 1] = saturate((n2 + (longint'(1) <<< (tes_pkg::FRAC_Z - 1)))
                              >>> tes_pkg::FRAC_Z, HIST_MIN, HIST_MAX, spill);
    return y;
  endfunction

  function automatic filtered_t tilt_filter(audio_t a);
    filtered_t r;
    longint    y;
    bit        clip;
    clip = 1'b0;
    if (a.chan < tes_pkg::NUM_CHANNELS) begin
      y = shelf_stage(int'(a.chan) * 4, 1'b0, a.sample, clip);
      y = shelf_stage(int'(a.chan) * 4 + 2, 1'b1, y, clip);
    end else begin
      y = saturate(a.sample, SMP_MIN, SMP_MAX, clip);
    end
    r.chan   = a.chan;
    r.sample = y[tes_pkg::SAMPLE_BITS-1:0];
    r.last   = a.last;
    r.clip   = clip;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample feed, result drain and checking
  // ---------------------------------------------------------------------------
  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  always @(negedge clk_i) begin : feed_p
    int     gap;
    audio_t nxt;
    if (rst_ni && (!smp.valid || in_fire)) begin
      gap = in_fire ? draw_wait() : in_gap;
      if (gap == 0 && sample_feed.size() != 0) begin
        nxt = sample_feed.pop_front();
        smp.valid      <= 1'b1;
        smp.chan_index <= nxt.chan;
        smp.sample_in  <= nxt.sample;
        smp.block_end  <= nxt.last;
        in_gap         <= 0;
      end else begin
        smp.valid <= 1'b0;
        in_gap    <= (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  always @(negedge clk_i) begin : drain_p
    int stall;
    if (rst_ni) begin
      stall = out_fire ? draw_wait() : out_stall;
      res.ready <= (stall == 0);
      out_stall <= (stall > 0) ? stall - 1 : 0;
    end
  end

  always @(posedge clk_i) begin : check_p
    filtered_t want;
    audio_t    got;
    in_fire  <= rst_ni && smp.valid && smp.ready;
    out_fire <= rst_ni && res.valid && res.ready;
    if (rst_ni && res.valid && res.ready) begin
      if (filtered_due.size() == 0) begin
        $error("unexpected result: chan_out %0d sample_out %0d", res.chan_out,
               res.sample_out);
        err_count++;
      end else begin
        want = filtered_due.pop_front();
        if (res.chan_out !== want.chan) begin
          $error("chan_out: expected %0d, got %0d", want.chan, res.chan_out);
          err_count++;
        end
        if (res.sample_out !== want.sample) begin
          $error("sample_out: expected %0d, got %0d", want.sample, res.sample_out);
          err_count++;
        end
        if (res.block_end_out !== want.last) begin
          $error("block_end_out: expected %0b, got %0b", want.last, res.block_end_out);
          err_count++;
        end
        if (res.clipped !== want.clip) begin
          $error("clipped: expected %0b, got %0b", want.clip, res.clipped);
          err_count++;
        end
      end
    end
    // compare before queuing so a stray result cannot match a fresh item
    if (rst_ni && smp.valid && smp.ready) begin
      got.chan   = smp.chan_index;
      got.sample = smp.sample_in;
      got.last   = smp.block_end;
      filtered_due.push_back(tilt_filter(got));
    end
  end

  // ---------------------------------------------------------------------------
  // Coefficient programming and stimulus
  // ---------------------------------------------------------------------------
  task automatic drain_all();
    while (sample_feed.size() != 0 || smp.valid || filtered_due.size() != 0)
      @(posedge clk_i);
    // let the block finish its history write-back
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_coef(input logic [tes_pkg::REG_IDX_W-1:0] idx,
                            input logic [tes_pkg::PAIR_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    if (idx < tes_pkg::NUM_REGS) begin
      coef_pair[idx] = data;
      foreach (hist[i]) hist[i] = 0;
    end
  endtask

  function automatic logic [tes_pkg::COEF_W-1:0] pick_half(coef_set_e mode,
                                                           tes_pkg::coef_e r);
    int span;
    int center;
    center = 0;
    span   = 'h8_0000;
    case (mode)
      CFG_MAX:  return COEF_MAX;
      CFG_MIN:  return COEF_MIN;
      CFG_ONES: return '1;
      CFG_GENTLE: begin
        // poles stay well inside the unit circle: |a2| <= 0.375, |a1| < 0.57
        case (r)
          tes_pkg::REG_B0: begin
            center = COEF_ONE;
            span   = 'h4_0000;
          end
          tes_pkg::REG_A1: span = 'h9_0000;
          tes_pkg::REG_A2: span = 'h6_0000;
          default: span = 'h8_0000;
        endcase
        return tes_pkg::COEF_W'(center + int'($urandom_range(0, 2 * span)) - span);
      end
      CFG_MIXED: begin
        case ($urandom_range(0, 4))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return '1;
          3: return '0;
          default: return tes_pkg::COEF_W'($urandom);
        endcase
      end
      default: return tes_pkg::COEF_W'($urandom);
    endcase
  endfunction

  task automatic program_phase(input coef_set_e mode);
    drain_all();
    if (mode == CFG_SPARE) begin
      // indexes past the last register: coefficients and history must survive
      for (int r = tes_pkg::NUM_REGS; r < (1 << tes_pkg::REG_IDX_W); r++)
        write_coef(tes_pkg::REG_IDX_W'(r), tes_pkg::PAIR_W'({$urandom, $urandom}));
    end else begin
      for (int r = 0; r < tes_pkg::NUM_REGS; r++)
        write_coef(tes_pkg::REG_IDX_W'(r), (mode == CFG_DEFAULT) ? tes_pkg::COEF_RESET[r]
                   : {pick_half(mode, tes_pkg::coef_e'(r)),
                      pick_half(mode, tes_pkg::coef_e'(r))});
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly multichannel frames ending in block_end, with some loose noise items.
  task automatic queue_phase(input int n_items);
    int     left;
    int     len;
    int     ch;
    int     style;
    int     amp;
    audio_t item;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        item.chan   = tes_pkg::CHAN_W'($urandom);
        item.sample = tes_pkg::SAMPLE_BITS'($urandom);
        item.last   = 1'($urandom);
        sample_feed.push_back(item);
        left--;
      end else begin
        len   = $urandom_range(1, 8);
        ch    = $urandom_range(0, tes_pkg::NUM_CHANNELS - 1);
        style = $urandom_range(0, 3);
        amp   = $urandom_range(0, 1 << (tes_pkg::SAMPLE_BITS - 2));
        for (int k = 0; k < len && left > 0; k++) begin
          item.chan = tes_pkg::CHAN_W'((ch + k) % tes_pkg::NUM_CHANNELS);
          item.last = (k == len - 1);
          case (style)
            0: item.sample = tes_pkg::SAMPLE_BITS'($urandom);
            1: item.sample = tes_pkg::SAMPLE_BITS'(int'($urandom_range(0, 4095)) - 2048);
            2: item.sample = $urandom_range(0, 1) ? tes_pkg::SAMPLE_BITS'(SMP_MAX)
                                                  : tes_pkg::SAMPLE_BITS'(SMP_MIN);
            default: item.sample = tes_pkg::SAMPLE_BITS'((k % 2) ? amp : -amp);
          endcase
          sample_feed.push_back(item);
          left--;
        end
      end
    end
  endtask

  initial begin : stim_p
    audio_t item;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    smp.valid      = 1'b0;
    smp.chan_index = '0;
    smp.sample_in  = '0;
    smp.block_end  = 1'b0;
    res.ready      = 1'b0;
    err_count      = 0;
    no_idle        = 1'b0;
    foreach (coef_pair[r]) coef_pair[r] = tes_pkg::COEF_RESET[r];
    foreach (hist[i]) hist[i] = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset coefficients are unity: full-scale samples on every channel
    for (int k = 0; k < 10; k++) begin
      item.chan   = tes_pkg::CHAN_W'(k % tes_pkg::NUM_CHANNELS);
      item.sample = EDGE_SAMPLES[k];
      item.last   = k[0];
      sample_feed.push_back(item);
    end
    // full-scale gain and feedback: output clips, history saturates
    program_phase(CFG_MAX);
    for (int k = 0; k < 8; k++) begin
      item.chan   = tes_pkg::CHAN_W'(k % 3);
      item.sample = EDGE_SAMPLES[k];
      item.last   = (k == 7);
      sample_feed.push_back(item);
    end

    foreach (PLAN[p]) begin
      program_phase(PLAN[p]);
      no_idle = (p % 4 == 3);
      queue_phase(PHASE_ITEMS);
    end

    drain_all();
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog_p
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tes_pkg.sv
rtl/tes_stream_if.sv
rtl/tes_sequencer.sv
rtl/tes_datapath.sv
rtl/tilt_eq_shelf_cascade.sv
tb/tilt_eq_shelf_cascade_tb.sv
